### hdl/pre_pkg.sv
// Shared types, constants and codes of the page replacement engine.
`timescale 1ns / 1ps
package pre_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int FRAME_BITS = $clog2(MAX_FRAMES);
    localparam int COUNT_BITS = FRAME_BITS + 1;
    localparam int PAGE_BITS  = 20;
    localparam int STAMP_BITS = 32;
    localparam int TOTAL_BITS = 32;
    localparam int LFSR_BITS  = 16;
    localparam int CFG_BITS   = 7;

    localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0] MODE_RANDOM = 2'd0;
    localparam logic [1:0] MODE_LRU    = 2'd1;
    localparam logic [1:0] MODE_CLOCK  = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_FRAMES = 2'd1;

    typedef struct packed {
        logic [PAGE_BITS-1:0]  page;
        logic                  dirty;
        logic [STAMP_BITS-1:0] stamp;
        logic                  referenced;
    } t_frame_word;

    localparam int WORD_BITS = $bits(t_frame_word);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RAND_MOD,
        S_VREAD,
        S_VCAP,
        S_CLK_RD,
        S_CLK_CHK,
        S_UPDATE
    } t_state;

    typedef enum logic [1:0] {
        RD_SCAN,
        RD_FRAME,
        RD_CLOCK
    } t_rd_sel;

    typedef struct packed {
        logic    start;
        logic    scan;
        logic    decide;
        logic    rand_iter;
        logic    capture;
        logic    clk_advance;
        logic    clk_done;
        logic    update;
        t_rd_sel rd_sel;
    } t_cmd;

    typedef struct packed {
        logic       scan_done;
        logic       hit;
        logic       fill;
        logic [1:0] mode;
        logic       rem_done;
        logic       clk_ref;
        logic       out_free;
    } t_status;

endpackage

### hdl/page_replacement_engine.sv
// Top level of the page replacement engine.
`timescale 1ns / 1ps
// Demand-paging engine: each request carries a page number and a write flag and returns
// one result saying whether the page was resident, which frame holds it and, on a fault
// with all managed frames in use, which page was evicted and whether it needs writing
// back. Residency is found by walking the frame table in its RAM, one frame a cycle. An
// eviction by least recently used comes out of that same walk and then reads the victim's
// entry; a random eviction first runs the remainder unit and then reads the victim's entry;
// a clock eviction reads and checks every frame the hand examines, the chosen one included.
// Requests are handled one at a time. No clearing pass is needed after reset.
// Configuration is to be written only while the engine is idle; the engine itself does
// not enforce this.
module page_replacement_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [1:0]                     i_cfg_index,
    input  logic [pre_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pre_pkg::PAGE_BITS-1:0]  i_page_number,
    input  logic                           i_is_write,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_hit,
    output logic [pre_pkg::FRAME_BITS-1:0] o_frame_index,
    output logic                           o_evicted,
    output logic [pre_pkg::PAGE_BITS-1:0]  o_replaced_page,
    output logic                           o_victim_dirty,
    output logic [pre_pkg::TOTAL_BITS-1:0] o_fault_total,
    output logic [pre_pkg::TOTAL_BITS-1:0] o_writeback_total
);

    pre_pkg::t_cmd    cmd;
    pre_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    pre_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    pre_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_page_number     (i_page_number),
        .i_is_write        (i_is_write),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_hit             (o_hit),
        .o_frame_index     (o_frame_index),
        .o_evicted         (o_evicted),
        .o_replaced_page   (o_replaced_page),
        .o_victim_dirty    (o_victim_dirty),
        .o_fault_total     (o_fault_total),
        .o_writeback_total (o_writeback_total)
    );

`ifndef SYNTHESIS
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_evicted)
        else $error("hit result reports an eviction");

    a_no_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted |-> o_replaced_page == '0 && !o_victim_dirty)
        else $error("victim fields set without eviction");

    a_wb_le_faults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_writeback_total <= o_fault_total)
        else $error("write-backs exceed faults");

    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request taken while previous one in progress");
`endif

endmodule

### hdl/pre_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/pre_ctrl.sv
// Sequencing state machine of the page replacement engine.
`timescale 1ns / 1ps
module pre_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pre_pkg::t_status i_status,
    output logic            o_ready,
    output pre_pkg::t_cmd   o_cmd
);

    pre_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pre_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pre_pkg::S_IDLE: begin
                if (i_valid) n_state = pre_pkg::S_SCAN;
            end
            pre_pkg::S_SCAN: begin
                if (i_status.scan_done) n_state = pre_pkg::S_DECIDE;
            end
            pre_pkg::S_DECIDE: begin
                priority if (i_status.hit || i_status.fill) begin
                    n_state = pre_pkg::S_UPDATE;
                end else if (i_status.mode == pre_pkg::MODE_RANDOM) begin
                    n_state = pre_pkg::S_RAND_MOD;
                end else if (i_status.mode == pre_pkg::MODE_CLOCK) begin
                    n_state = pre_pkg::S_CLK_RD;
                end else begin
                    n_state = pre_pkg::S_VREAD;
                end
            end
            pre_pkg::S_RAND_MOD: begin
                if (i_status.rem_done) n_state = pre_pkg::S_VREAD;
            end
            pre_pkg::S_VREAD:   n_state = pre_pkg::S_VCAP;
            pre_pkg::S_VCAP:    n_state = pre_pkg::S_UPDATE;
            pre_pkg::S_CLK_RD:  n_state = pre_pkg::S_CLK_CHK;
            pre_pkg::S_CLK_CHK: begin
                n_state = i_status.clk_ref ? pre_pkg::S_CLK_RD : pre_pkg::S_UPDATE;
            end
            pre_pkg::S_UPDATE: begin
                if (i_status.out_free) n_state = pre_pkg::S_IDLE;
            end
            default: n_state = pre_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_cmd.rd_sel = pre_pkg::RD_SCAN;
        o_ready = 1'b0;
        unique case (r_state)
            pre_pkg::S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.start = i_valid;
            end
            pre_pkg::S_SCAN:     o_cmd.scan = 1'b1;
            pre_pkg::S_DECIDE:   o_cmd.decide = 1'b1;
            pre_pkg::S_RAND_MOD: o_cmd.rand_iter = 1'b1;
            pre_pkg::S_VREAD:    o_cmd.rd_sel = pre_pkg::RD_FRAME;
            pre_pkg::S_VCAP:     o_cmd.capture = 1'b1;
            pre_pkg::S_CLK_RD:   o_cmd.rd_sel = pre_pkg::RD_CLOCK;
            pre_pkg::S_CLK_CHK: begin
                o_cmd.clk_advance = i_status.clk_ref;
                o_cmd.clk_done    = !i_status.clk_ref;
            end
            pre_pkg::S_UPDATE:   o_cmd.update = i_status.out_free;
            default: ;
        endcase
    end

endmodule

### hdl/pre_datapath.sv
// Frame table, counters, victim selection and output register.
`timescale 1ns / 1ps
module pre_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pre_pkg::t_cmd                     i_cmd,
    output pre_pkg::t_status                  o_status,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_index,
    input  logic [pre_pkg::CFG_BITS-1:0]      i_cfg_data,
    input  logic [pre_pkg::PAGE_BITS-1:0]     i_page_number,
    input  logic                              i_is_write,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_hit,
    output logic [pre_pkg::FRAME_BITS-1:0]    o_frame_index,
    output logic                              o_evicted,
    output logic [pre_pkg::PAGE_BITS-1:0]     o_replaced_page,
    output logic                              o_victim_dirty,
    output logic [pre_pkg::TOTAL_BITS-1:0]    o_fault_total,
    output logic [pre_pkg::TOTAL_BITS-1:0]    o_writeback_total
);

    localparam int FB = pre_pkg::FRAME_BITS;
    localparam int CB = pre_pkg::COUNT_BITS;
    localparam int LB = pre_pkg::LFSR_BITS;
    localparam int TB = pre_pkg::TOTAL_BITS;
    localparam int SB = pre_pkg::STAMP_BITS;
    localparam int DB = $clog2(LB + 1);
    localparam int IB = $clog2(LB);
    localparam logic [CB-1:0] MAX_N = CB'(pre_pkg::MAX_FRAMES);

    logic [1:0]                    r_mode;
    logic [pre_pkg::CFG_BITS-1:0]  r_frames_cfg;
    logic [CB-1:0]                 r_filled;
    logic [FB-1:0]                 r_clk_ptr;
    logic [SB-1:0]                 r_stamp;
    logic [LB-1:0]                 r_lfsr;
    logic [TB-1:0]                 r_faults;
    logic [TB-1:0]                 r_wbs;

    logic [pre_pkg::PAGE_BITS-1:0] r_page;
    logic                          r_wr;
    logic                          r_hit;
    logic                          r_evict;
    logic [FB-1:0]                 r_frame;
    pre_pkg::t_frame_word          r_word;
    logic [CB-1:0]                 r_idx;
    logic                          r_pend;
    logic [FB-1:0]                 r_pend_idx;
    logic [FB-1:0]                 r_best;
    logic [SB-1:0]                 r_min;
    logic [FB-1:0]                 r_cp;
    logic [CB:0]                   r_rem;
    logic [DB-1:0]                 r_div_cnt;

    logic                          r_out_valid;
    logic                          r_o_hit;
    logic [FB-1:0]                 r_o_frame;
    logic                          r_o_evicted;
    logic [pre_pkg::PAGE_BITS-1:0] r_o_vpage;
    logic                          r_o_vdirty;

    logic [CB-1:0]        n_active;
    logic [FB-1:0]        n_cp_next;
    logic [LB-1:0]        n_lfsr;
    logic [CB:0]          n_rem_shift;
    logic [SB-1:0]        n_stamp;
    logic [TB-1:0]        n_faults;
    logic [TB-1:0]        n_wbs;
    logic                 n_vdirty;
    logic                 ram_we;
    logic [FB-1:0]        ram_waddr;
    pre_pkg::t_frame_word ram_wdata;
    logic [FB-1:0]        ram_raddr;
    pre_pkg::t_frame_word ram_rdata;
    logic [pre_pkg::WORD_BITS-1:0] ram_rbits;

    // Clamp the configured frame count into one to the table depth.
    always_comb begin
        priority if (r_frames_cfg == '0) begin
            n_active = CB'(1);
        end else if (CB'(r_frames_cfg) > MAX_N) begin
            n_active = MAX_N;
        end else begin
            n_active = CB'(r_frames_cfg);
        end
    end

    assign n_cp_next = ((CB'(r_cp) + CB'(1)) == n_active) ? '0 : (r_cp + FB'(1));
    assign n_lfsr = r_lfsr[0] ? ((r_lfsr >> 1) ^ pre_pkg::LFSR_TAPS) : (r_lfsr >> 1);
    assign n_rem_shift = {r_rem[CB-1:0], r_lfsr[IB'(r_div_cnt - DB'(1))]};
    assign n_stamp = (r_stamp == '1) ? r_stamp : (r_stamp + SB'(1));
    assign n_vdirty = r_evict & r_word.dirty;
    assign n_faults = (!r_hit && r_faults != '1) ? (r_faults + TB'(1)) : r_faults;
    assign n_wbs = (n_vdirty && r_wbs != '1) ? (r_wbs + TB'(1)) : r_wbs;

    always_comb begin
        unique case (i_cmd.rd_sel)
            pre_pkg::RD_SCAN:  ram_raddr = r_idx[FB-1:0];
            pre_pkg::RD_FRAME: ram_raddr = r_frame;
            pre_pkg::RD_CLOCK: ram_raddr = r_cp;
            default:           ram_raddr = r_idx[FB-1:0];
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_frame;
        ram_wdata = ram_rdata;
        if (i_cmd.clk_advance) begin
            ram_we                = 1'b1;
            ram_waddr             = r_cp;
            ram_wdata.referenced  = 1'b0;
        end else if (i_cmd.update) begin
            ram_we               = 1'b1;
            ram_wdata.page       = r_page;
            ram_wdata.dirty      = (r_hit & r_word.dirty) | r_wr;
            ram_wdata.stamp      = n_stamp;
            ram_wdata.referenced = 1'b1;
        end
    end

    pre_ram #(
        .WIDTH (pre_pkg::WORD_BITS),
        .DEPTH (pre_pkg::MAX_FRAMES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = pre_pkg::t_frame_word'(ram_rbits);

    // Control and running state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= pre_pkg::MODE_LRU;
            r_frames_cfg <= pre_pkg::CFG_BITS'(pre_pkg::MAX_FRAMES);
            r_filled     <= '0;
            r_clk_ptr    <= '0;
            r_stamp      <= '0;
            r_lfsr       <= pre_pkg::LFSR_SEED;
            r_faults     <= '0;
            r_wbs        <= '0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
            r_idx        <= '0;
            r_div_cnt    <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == pre_pkg::CFG_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end
            if (i_cfg_we && i_cfg_index == pre_pkg::CFG_FRAMES) begin
                r_frames_cfg <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= (r_idx < r_filled);
                if (r_idx < r_filled) r_idx <= r_idx + CB'(1);
            end
            if (i_cmd.decide && !r_hit && (r_filled < n_active)) begin
                r_filled <= r_filled + CB'(1);
            end
            if (i_cmd.decide && !r_hit && !(r_filled < n_active)
                    && r_mode == pre_pkg::MODE_RANDOM) begin
                r_lfsr    <= n_lfsr;
                r_div_cnt <= DB'(LB);
            end
            if (i_cmd.rand_iter && r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - DB'(1);
            end
            if (i_cmd.clk_done) begin
                r_clk_ptr <= n_cp_next;
            end
            if (i_cmd.update) begin
                r_stamp  <= n_stamp;
                r_faults <= n_faults;
                r_wbs    <= n_wbs;
            end
            if (i_cmd.update) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-request working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page  <= i_page_number;
            r_wr    <= i_is_write;
            r_hit   <= 1'b0;
            r_evict <= 1'b0;
        end
        if (i_cmd.scan) begin
            r_pend_idx <= r_idx[FB-1:0];
            if (r_pend) begin
                if (ram_rdata.page == r_page) begin
                    r_hit   <= 1'b1;
                    r_frame <= r_pend_idx;
                    r_word  <= ram_rdata;
                end
                // Oldest stamp among managed frames; strict compare keeps lowest index.
                if (CB'(r_pend_idx) < n_active
                        && (r_pend_idx == '0 || ram_rdata.stamp < r_min)) begin
                    r_min  <= ram_rdata.stamp;
                    r_best <= r_pend_idx;
                end
            end
        end
        if (i_cmd.decide && !r_hit) begin
            if (r_filled < n_active) begin
                r_frame <= r_filled[FB-1:0];
            end else begin
                r_evict <= 1'b1;
                r_rem   <= '0;
                r_frame <= r_best;
                r_cp    <= (CB'(r_clk_ptr) >= n_active) ? '0 : r_clk_ptr;
            end
        end
        // Restoring remainder, one dividend bit per cycle.
        if (i_cmd.rand_iter && r_div_cnt != '0) begin
            if (n_rem_shift >= (CB+1)'(n_active)) begin
                r_rem <= n_rem_shift - (CB+1)'(n_active);
            end else begin
                r_rem <= n_rem_shift;
            end
        end
        if (i_cmd.rand_iter && r_div_cnt == '0) begin
            r_frame <= r_rem[FB-1:0];
        end
        if (i_cmd.capture) begin
            r_word <= ram_rdata;
        end
        if (i_cmd.clk_advance) begin
            r_cp <= n_cp_next;
        end
        if (i_cmd.clk_done) begin
            r_frame <= r_cp;
            r_word  <= ram_rdata;
        end
        if (i_cmd.update) begin
            r_o_hit     <= r_hit;
            r_o_frame   <= r_frame;
            r_o_evicted <= r_evict;
            r_o_vpage   <= r_evict ? r_word.page : '0;
            r_o_vdirty  <= n_vdirty;
        end
    end

    always_comb begin
        o_status.scan_done = !r_pend && !(r_idx < r_filled);
        o_status.hit       = r_hit;
        o_status.fill      = r_filled < n_active;
        o_status.mode      = r_mode;
        o_status.rem_done  = i_cmd.rand_iter && r_div_cnt == '0;
        o_status.clk_ref   = ram_rdata.referenced;
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_o_hit;
    assign o_frame_index     = r_o_frame;
    assign o_evicted         = r_o_evicted;
    assign o_replaced_page   = r_o_vpage;
    assign o_victim_dirty    = r_o_vdirty;
    assign o_fault_total     = r_faults;
    assign o_writeback_total = r_wbs;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the page replacement engine: directed accesses and random access streams against a model.
`timescale 1ns / 1ps
module tb_top;

    localparam int FRAME_BITS = pre_pkg::FRAME_BITS;
    localparam int PAGE_BITS  = pre_pkg::PAGE_BITS;
    localparam int TOTAL_BITS = pre_pkg::TOTAL_BITS;
    localparam int CFG_BITS   = pre_pkg::CFG_BITS;
    localparam int MAX_FRAMES = pre_pkg::MAX_FRAMES;
    localparam int STAMP_BITS = pre_pkg::STAMP_BITS;
    localparam int LFSR_BITS  = pre_pkg::LFSR_BITS;
    // Mode code with no policy of its own
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame;
        logic                  evicted;
        logic [PAGE_BITS-1:0]  vpage;
        logic                  vdirty;
        logic [TOTAL_BITS-1:0] faults;
        logic [TOTAL_BITS-1:0] wbacks;
    } t_outcome;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 wr;
    } t_access;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int POOL_SIZE      = 24;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [1:0]             i_cfg_index = '0;
    logic [CFG_BITS-1:0]    i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [PAGE_BITS-1:0]   i_page_number = '0;
    logic                   i_is_write = 1'b0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_hit;
    logic [FRAME_BITS-1:0]  o_frame_index;
    logic                   o_evicted;
    logic [PAGE_BITS-1:0]   o_replaced_page;
    logic                   o_victim_dirty;
    logic [TOTAL_BITS-1:0]  o_fault_total;
    logic [TOTAL_BITS-1:0]  o_writeback_total;

    page_replacement_engine uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state of the paging tables
    logic [FRAME_BITS-1:0]  page_frame [logic [PAGE_BITS-1:0]];
    logic [PAGE_BITS-1:0]   frame_page_m  [MAX_FRAMES];
    logic                   frame_dirty_m [MAX_FRAMES];
    logic [STAMP_BITS-1:0]  frame_stamp_m [MAX_FRAMES];
    logic                   frame_ref_m   [MAX_FRAMES];
    int unsigned            filled_m, hand_m;
    logic [STAMP_BITS-1:0]  stamp_m;
    logic [LFSR_BITS-1:0]   lfsr_m;
    logic [TOTAL_BITS-1:0]  faults_m, wbacks_m;
    logic [1:0]             mode_m = pre_pkg::MODE_LRU;
    logic [CFG_BITS-1:0]    frames_cfg_m = 7'd64;

    t_access  pending_accesses[$];
    t_outcome expected_results[$];
    int       errors = 0;
    int       idle_cycles = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void touch_frame(int f);
        stamp_m = sat_inc(stamp_m);
        frame_stamp_m[f] = stamp_m;
        frame_ref_m[f] = 1'b1;
    endfunction

    function automatic t_outcome resolve_access(t_access a);
        t_outcome r;
        int n, f, p;
        r = '0;
        n = (frames_cfg_m == 0) ? 1 : (frames_cfg_m > MAX_FRAMES) ? MAX_FRAMES
                                                                   : int'(frames_cfg_m);
        if (page_frame.exists(a.page)) begin
            r.hit = 1'b1;
            f = int'(page_frame[a.page]);
            touch_frame(f);
        end else begin
            faults_m = sat_inc(faults_m);
            if (filled_m < n) begin
                f = filled_m;
                filled_m++;
            end else begin
                if (mode_m == pre_pkg::MODE_RANDOM) begin
                    lfsr_m = lfsr_m[0] ? ((lfsr_m >> 1) ^ pre_pkg::LFSR_TAPS) : (lfsr_m >> 1);
                    f = int'(lfsr_m) % n;
                end else if (mode_m == pre_pkg::MODE_CLOCK) begin
                    p = (hand_m >= n) ? 0 : hand_m;
                    for (int i = 0; i < n; i++) begin
                        if (!frame_ref_m[p]) break;
                        frame_ref_m[p] = 1'b0;
                        p = (p + 1) % n;
                    end
                    hand_m = (p + 1) % n;
                    f = p;
                end else begin
                    // oldest stamp, lowest index on a tie
                    f = 0;
                    for (int i = 1; i < n; i++)
                        if (frame_stamp_m[i] < frame_stamp_m[f]) f = i;
                end
                r.evicted = 1'b1;
                r.vpage = frame_page_m[f];
                r.vdirty = frame_dirty_m[f];
                page_frame.delete(r.vpage);
                if (r.vdirty) wbacks_m = sat_inc(wbacks_m);
            end
            frame_page_m[f] = a.page;
            frame_dirty_m[f] = 1'b0;
            touch_frame(f);
            page_frame[a.page] = FRAME_BITS'(f);
        end
        if (a.wr) frame_dirty_m[f] = 1'b1;
        r.frame = FRAME_BITS'(f);
        r.faults = faults_m;
        r.wbacks = wbacks_m;
        return r;
    endfunction

    // Request driver: bursts of random length separated by random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                expected_results.push_back(resolve_access('{i_page_number, i_is_write}));
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_accesses.size() > 0) begin
                    t_access a;
                    a = pending_accesses.pop_front();
                    i_page_number <= a.page;
                    i_is_write <= a.wr;
                    i_valid <= 1'b1;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
            errors++;
        end
    endtask

    // Result monitor with its own stall pattern
    int stall_idx = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= stall_pattern[stall_idx];
            stall_idx = (stall_idx + 1) % 16;
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, frame %0h", $time, o_frame_index);
                    errors++;
                end else begin
                    t_outcome e;
                    e = expected_results.pop_front();
                    check_field("hit", 32'(e.hit), 32'(o_hit));
                    check_field("frame_index", 32'(e.frame), 32'(o_frame_index));
                    check_field("evicted", 32'(e.evicted), 32'(o_evicted));
                    check_field("replaced_page", 32'(e.vpage), 32'(o_replaced_page));
                    check_field("victim_dirty", 32'(e.vdirty), 32'(o_victim_dirty));
                    check_field("fault_total", e.faults, o_fault_total);
                    check_field("writeback_total", e.wbacks, o_writeback_total);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_register(logic [1:0] idx, logic [CFG_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == pre_pkg::CFG_MODE) mode_m = data[1:0];
        else frames_cfg_m = data;
    endtask

    // Hold until every request has been answered and the engine is quiet
    task automatic drain();
        while (pending_accesses.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic queue_stream(int count, int span);
        t_access a;
        for (int i = 0; i < count; i++) begin
            a.page = ($urandom_range(0, 9) == 0) ? PAGE_BITS'($urandom())
                                                  : page_pool[$urandom_range(0, span - 1)];
            a.wr = 1'($urandom_range(0, 1));
            pending_accesses.push_back(a);
        end
    endtask

    logic [1:0]          phase_modes  [10] = '{pre_pkg::MODE_CLOCK, pre_pkg::MODE_RANDOM,
                                               MODE_UNUSED, pre_pkg::MODE_LRU,
                                               pre_pkg::MODE_CLOCK, pre_pkg::MODE_RANDOM,
                                               pre_pkg::MODE_LRU, pre_pkg::MODE_CLOCK,
                                               pre_pkg::MODE_RANDOM, MODE_UNUSED};
    logic [CFG_BITS-1:0] phase_frames [10] = '{7'd4, 7'd0, 7'd127, 7'd1, 7'd64,
                                               7'd2, 7'd6, 7'd3, 7'd8, 7'd5};

    initial begin
        filled_m = 0; hand_m = 0; stamp_m = '0; lfsr_m = pre_pkg::LFSR_SEED;
        faults_m = '0; wbacks_m = '0;
        foreach (frame_page_m[i]) begin
            frame_page_m[i] = '0; frame_dirty_m[i] = 0; frame_stamp_m[i] = '0; frame_ref_m[i] = 0;
        end
        page_pool[0] = '0;
        page_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = PAGE_BITS'($urandom());
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, read and write hits, fills under reset settings
        pending_accesses.push_back('{'0, 1'b0});
        pending_accesses.push_back('{'1, 1'b1});
        pending_accesses.push_back('{'0, 1'b1});
        pending_accesses.push_back('{'1, 1'b0});
        pending_accesses.push_back('{20'h55555, 1'b1});
        pending_accesses.push_back('{20'hAAAAA, 1'b0});
        for (int i = 0; i < 8; i++) pending_accesses.push_back('{PAGE_BITS'(i + 16), i[0]});
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            stall_pattern = (ph % 3 == 0) ? 16'hFFFF : 16'($urandom()) | 16'h0101;
            write_register(pre_pkg::CFG_MODE, {5'd0, phase_modes[ph]});
            write_register(pre_pkg::CFG_FRAMES, phase_frames[ph]);
            queue_stream(43, (phase_frames[ph] > 16) ? POOL_SIZE : $urandom_range(4, 12));
            drain();
        end

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hdl/pre_pkg.sv
hdl/pre_ram.sv
hdl/pre_ctrl.sv
hdl/pre_datapath.sv
hdl/page_replacement_engine.sv
verif/tb_top.sv
